// File: rtl/wsd_pkg.sv
// shared types and constants for the websocket frame deframer
// no dependencies; imported by the top level and the front, queue and back modules

package wsd_pkg;

   localparam int LENGTH_WIDTH = 64;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [6:0] LEN_CODE_16 = 7'd126;
   localparam logic [6:0] LEN_CODE_64 = 7'd127;

   // extended length and masking key byte counts, minus one
   localparam logic [2:0] EXT_LAST_16 = 3'd1;
   localparam logic [2:0] EXT_LAST_64 = 3'd7;
   localparam logic [1:0] KEY_LAST    = 2'd3;

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXT,
      PH_KEY,
      PH_DATA
   } phase_type;

   typedef struct packed {
      logic       is_key;
      logic       emit;
      logic       has_data;
      logic       masked;
      logic [7:0] data;
      logic [3:0] opcode;
      logic       frame_end;
      logic       message_end;
   } entry_type;

endpackage

// File: rtl/websocket_frame_deframer.sv
// websocket frame deframer, receive side
// request channel: one byte of the framed stream per request (req_valid, req_stall)
// response channel: one payload byte or empty-frame marker per response (rsp_valid,
// rsp_stall), tagged with the message opcode and frame-end / message-end flags
// header, extended length and key bytes give no response; an empty frame gives one
// marker with rsp_has_data low on the byte that completes its header
// the parser takes one byte per cycle while req_stall is low; a payload byte passes
// through the queue into the rsp_* response register; sustained rate with rsp_stall low
// is one byte per cycle, set by the parser and the one-entry-per-cycle output stage
// a four-entry queue separates parser and output side, so a stalled response
// keeps the parser running until the queue fills; then req_stall rises
// synchronous reset returns to waiting for the first header byte, clears the
// masking key and empties the queue and the response register
// depends on wsd_pkg, wsd_front, wsd_queue, wsd_back

module websocket_frame_deframer
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_data,
   output logic [3:0] rsp_msg_opcode,
   output logic       rsp_frame_end,
   output logic       rsp_message_end
);

   logic      q_full;
   logic      q_push;
   entry_type q_entry;
   logic      q_pop;
   logic      q_head_valid;
   entry_type q_head;

   wsd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (q_entry)
   );

   wsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head)
   );

   wsd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (q_head_valid),
      .head_entry      (q_head),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_has_data    (rsp_has_data),
      .rsp_msg_opcode  (rsp_msg_opcode),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_message_end (rsp_message_end)
   );

endmodule

// File: rtl/wsd_front.sv
// header parser: walks frame headers and pushes key, payload and marker entries
// depends on wsd_pkg

module wsd_front
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       q_full,
   output logic       q_push,
   output entry_type  q_entry
);

   phase_type               phase_ff, phase_in;
   logic [2:0]              ext_count_ff, ext_count_in;
   logic [1:0]              key_count_ff, key_count_in;
   logic                    fin_ff, fin_in;
   logic                    masked_ff, masked_in;
   logic [3:0]              cur_opcode_ff, cur_opcode_in;
   logic                    mid_message_ff, mid_message_in;
   logic [LENGTH_WIDTH-1:0] remaining_ff, remaining_in;

   logic                    accept;
   logic [6:0]              len_code;
   logic [LENGTH_WIDTH-1:0] ext_shift;
   logic                    last_data;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign len_code  = req_in_byte[6:0];
   assign ext_shift = {remaining_ff[LENGTH_WIDTH-9:0], req_in_byte};
   assign last_data = (remaining_ff == LENGTH_WIDTH'(1));

   always_comb begin
      phase_in       = phase_ff;
      ext_count_in   = ext_count_ff;
      key_count_in   = key_count_ff;
      fin_in         = fin_ff;
      masked_in      = masked_ff;
      cur_opcode_in  = cur_opcode_ff;
      mid_message_in = mid_message_ff;
      remaining_in   = remaining_ff;

      q_push              = 1'b0;
      q_entry.is_key      = 1'b0;
      q_entry.emit        = 1'b0;
      q_entry.has_data    = 1'b0;
      q_entry.masked      = masked_ff;
      q_entry.data        = 8'd0;
      q_entry.opcode      = cur_opcode_ff;
      q_entry.frame_end   = 1'b1;
      q_entry.message_end = fin_ff;

      if (accept) begin
         case (phase_ff)
            PH_HDR0: begin
               fin_in = req_in_byte[7];
               if (!mid_message_ff) begin
                  cur_opcode_in = req_in_byte[3:0];
               end
               phase_in = PH_HDR1;
            end
            PH_HDR1: begin
               masked_in = req_in_byte[7];
               key_count_in = 2'd0;
               if (len_code == LEN_CODE_16 || len_code == LEN_CODE_64) begin
                  remaining_in = '0;
                  ext_count_in = (len_code == LEN_CODE_16) ? EXT_LAST_16 : EXT_LAST_64;
                  phase_in     = PH_EXT;
               end else begin
                  remaining_in = LENGTH_WIDTH'(len_code);
                  if (req_in_byte[7]) begin
                     phase_in = PH_KEY;
                  end else if (len_code == 7'd0) begin
                     // empty frame ends on its second header byte
                     q_push         = 1'b1;
                     q_entry.emit   = 1'b1;
                     mid_message_in = !fin_ff;
                     phase_in       = PH_HDR0;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end
            PH_EXT: begin
               remaining_in = ext_shift;
               if (ext_count_ff != 3'd0) begin
                  ext_count_in = ext_count_ff - 3'd1;
               end else if (masked_ff) begin
                  key_count_in = 2'd0;
                  phase_in     = PH_KEY;
               end else if (ext_shift == '0) begin
                  q_push         = 1'b1;
                  q_entry.emit   = 1'b1;
                  mid_message_in = !fin_ff;
                  phase_in       = PH_HDR0;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_KEY: begin
               q_push         = 1'b1;
               q_entry.is_key = 1'b1;
               q_entry.data   = req_in_byte;
               if (key_count_ff != KEY_LAST) begin
                  key_count_in = key_count_ff + 2'd1;
               end else if (remaining_ff == '0) begin
                  // last key byte also closes an empty masked frame
                  q_entry.emit   = 1'b1;
                  mid_message_in = !fin_ff;
                  phase_in       = PH_HDR0;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               q_push              = 1'b1;
               q_entry.emit        = 1'b1;
               q_entry.has_data    = 1'b1;
               q_entry.data        = req_in_byte;
               q_entry.frame_end   = last_data;
               q_entry.message_end = last_data && fin_ff;
               remaining_in        = remaining_ff - LENGTH_WIDTH'(1);
               if (last_data) begin
                  mid_message_in = !fin_ff;
                  phase_in       = PH_HDR0;
               end
            end
            default: begin
               phase_in = PH_HDR0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HDR0;
         ext_count_ff   <= 3'd0;
         key_count_ff   <= 2'd0;
         fin_ff         <= 1'b0;
         masked_ff      <= 1'b0;
         cur_opcode_ff  <= 4'd0;
         mid_message_ff <= 1'b0;
         remaining_ff   <= '0;
      end else begin
         phase_ff       <= phase_in;
         ext_count_ff   <= ext_count_in;
         key_count_ff   <= key_count_in;
         fin_ff         <= fin_in;
         masked_ff      <= masked_in;
         cur_opcode_ff  <= cur_opcode_in;
         mid_message_ff <= mid_message_in;
         remaining_ff   <= remaining_in;
      end
   end

endmodule

// File: rtl/wsd_queue.sv
// short fifo of parsed entries between the header parser and the output side
// depends on wsd_pkg

module wsd_queue
   import wsd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_entry
);

   entry_type mem_ff [QUEUE_DEPTH];

   logic [QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/wsd_back.sv
// output side: keeps the masking key, unmasks payload bytes, holds the response register
// depends on wsd_pkg

module wsd_back
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  entry_type  head_entry,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_data,
   output logic [3:0] rsp_msg_opcode,
   output logic       rsp_frame_end,
   output logic       rsp_message_end
);

   logic [31:0] mask_key_ff, mask_key_in;
   logic [1:0]  key_index_ff, key_index_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        has_data_ff;
   logic [3:0]  opcode_ff;
   logic        frame_end_ff;
   logic        message_end_ff;

   logic        load;
   logic [7:0]  key_byte;

   // key entries never wait on the response side, unless they also carry an empty-frame marker
   assign pop  = head_valid && (!head_entry.emit || !valid_ff || !rsp_stall);
   assign load = pop && head_entry.emit;

   always_comb begin
      case (key_index_ff)
         2'd0:    key_byte = mask_key_ff[31:24];
         2'd1:    key_byte = mask_key_ff[23:16];
         2'd2:    key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase
   end

   always_comb begin
      mask_key_in  = mask_key_ff;
      key_index_in = key_index_ff;
      byte_in      = 8'd0;
      if (pop && head_entry.is_key) begin
         mask_key_in  = {mask_key_ff[23:0], head_entry.data};
         key_index_in = 2'd0;
      end else if (pop && head_entry.has_data) begin
         key_index_in = key_index_ff + 2'd1;
      end
      if (head_entry.has_data) begin
         byte_in = head_entry.masked ? (head_entry.data ^ key_byte) : head_entry.data;
      end

      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && rsp_stall) begin
         valid_in = 1'b1;
      end else begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_key_ff  <= 32'd0;
         key_index_ff <= 2'd0;
         valid_ff     <= 1'b0;
      end else begin
         mask_key_ff  <= mask_key_in;
         key_index_ff <= key_index_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff        <= byte_in;
         has_data_ff    <= head_entry.has_data;
         opcode_ff      <= head_entry.opcode;
         frame_end_ff   <= head_entry.frame_end;
         message_end_ff <= head_entry.message_end;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_has_data    = has_data_ff;
   assign rsp_msg_opcode  = opcode_ff;
   assign rsp_frame_end   = frame_end_ff;
   assign rsp_message_end = message_end_ff;

endmodule

// File: rtl/wsd_checker.sv
// port-level checks for the websocket frame deframer, bound to the top level
// depends on websocket_frame_deframer

module wsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_in_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_has_data,
   input logic [3:0] rsp_msg_opcode,
   input logic       rsp_frame_end,
   input logic       rsp_message_end
);

   // a stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // an empty-frame marker always closes its frame
   a_marker_ends_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_data |-> rsp_frame_end)
      else $error("marker without frame end");

   a_marker_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_data |-> rsp_out_byte == 8'd0)
      else $error("marker carries a nonzero byte");

   // message end only on the last response of a frame
   a_msg_end_in_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_end |-> rsp_frame_end)
      else $error("message end without frame end");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);

// File: tb/websocket_frame_checker.sv
`timescale 1ns / 1ps
// response checker for the websocket frame deframer: parses the accepted request
// bytes into expected payload and marker responses and compares them with the response port
// depends on wsd_pkg

module websocket_frame_checker
   import wsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_has_data,
   input  logic [3:0]  rsp_msg_opcode,
   input  logic        rsp_frame_end,
   input  logic        rsp_message_end,
   output int unsigned error_count,
   output int unsigned pending_count
);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_data;
      logic [3:0] msg_opcode;
      logic       frame_end;
      logic       message_end;
   } frame_result_type;

   frame_result_type pending_results[$];
   int unsigned      errors;

   // parser state
   phase_type               stage;
   logic [2:0]              ext_left;
   logic                    frame_fin;
   logic                    frame_masked;
   logic [3:0]              message_opcode;
   logic                    in_message;
   logic [LENGTH_WIDTH-1:0] bytes_left;
   logic [31:0]             mask_key;
   logic [1:0]              key_pos;

   task automatic emit_result(input logic [7:0] value, input logic data, input logic fend);
      frame_result_type r;
      r.out_byte    = value;
      r.has_data    = data;
      r.msg_opcode  = message_opcode;
      r.frame_end   = fend;
      r.message_end = fend & frame_fin;
      pending_results.push_back(r);
      if (fend) begin
         in_message = !frame_fin;
         stage      = PH_HDR0;
      end
   endtask

   task automatic finish_header();
      key_pos = '0;
      if (bytes_left == '0)
         emit_result(8'h00, 1'b0, 1'b1);
      else
         stage = PH_DATA;
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      logic [7:0] value;
      case (stage)
         PH_HDR1: begin
            frame_masked = b[7];
            key_pos      = '0;
            if (b[6:0] == LEN_CODE_16) begin
               bytes_left = '0;
               ext_left   = EXT_LAST_16;
               stage      = PH_EXT;
            end else if (b[6:0] == LEN_CODE_64) begin
               bytes_left = '0;
               ext_left   = EXT_LAST_64;
               stage      = PH_EXT;
            end else begin
               bytes_left = LENGTH_WIDTH'(b[6:0]);
               if (frame_masked)
                  stage = PH_KEY;
               else
                  finish_header();
            end
         end
         PH_EXT: begin
            // big-endian, bits above the length width fall off
            bytes_left = (bytes_left << 8) | LENGTH_WIDTH'(b);
            if (ext_left != 3'd0)
               ext_left = ext_left - 3'd1;
            else if (frame_masked) begin
               key_pos = '0;
               stage   = PH_KEY;
            end else
               finish_header();
         end
         PH_KEY: begin
            mask_key = {mask_key[23:0], b};
            if (key_pos != KEY_LAST)
               key_pos = key_pos + 2'd1;
            else
               finish_header();
         end
         PH_DATA: begin
            value = b;
            if (frame_masked)
               value = value ^ mask_key[8 * (3 - key_pos) +: 8];
            key_pos    = key_pos + 2'd1;
            bytes_left = bytes_left - LENGTH_WIDTH'(1);
            emit_result(value, 1'b1, bytes_left == '0);
         end
         default: begin
            frame_fin = b[7];
            // continuation frames keep the opcode of the message's first frame
            if (!in_message)
               message_opcode = b[3:0];
            stage = PH_HDR1;
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         stage          = PH_HDR0;
         ext_left       = '0;
         frame_fin      = 1'b0;
         frame_masked   = 1'b0;
         message_opcode = '0;
         in_message     = 1'b0;
         bytes_left     = '0;
         mask_key       = '0;
         key_pos        = '0;
         errors         = 0;
         pending_results.delete();
      end else begin
         if (req_valid && !req_stall)
            deframe_byte(req_in_byte);
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $display({"%0t: unexpected response, expected none, ",
                         "actual byte %h data %b op %h fe %b me %b"},
                        $time, rsp_out_byte, rsp_has_data, rsp_msg_opcode, rsp_frame_end,
                        rsp_message_end);
               errors++;
            end else begin
               want = pending_results.pop_front();
               check_field("out_byte", want.out_byte, rsp_out_byte);
               check_field("has_data", 8'(want.has_data), 8'(rsp_has_data));
               check_field("msg_opcode", 8'(want.msg_opcode), 8'(rsp_msg_opcode));
               check_field("frame_end", 8'(want.frame_end), 8'(rsp_frame_end));
               check_field("message_end", 8'(want.message_end), 8'(rsp_message_end));
            end
         end
      end
      error_count   <= errors;
      pending_count <= pending_results.size();
   end

endmodule

// File: tb/websocket_frame_deframer_test.sv
`timescale 1ns / 1ps
// testbench top for the websocket frame deframer: drives framed byte streams with
// random gaps and response stalls, and gives the verdict from the checker's counts
// depends on wsd_pkg, websocket_frame_deframer and websocket_frame_checker

module websocket_frame_deframer_test;
   import wsd_pkg::*;

   localparam int unsigned TARGET_BYTES   = 600;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES   = 20;

   localparam logic [3:0] OP_CONTINUATION = 4'h0;
   localparam logic [3:0] OP_TEXT         = 4'h1;
   localparam logic [3:0] OP_BINARY       = 4'h2;
   localparam logic [3:0] OP_UNDEFINED_F  = 4'hF;

   typedef enum logic [1:0] {
      FORM_SHORT,
      FORM_16,
      FORM_64
   } length_form_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic        rsp_has_data;
   logic [3:0]  rsp_msg_opcode;
   logic        rsp_frame_end;
   logic        rsp_message_end;
   int unsigned error_count;
   int unsigned pending_count;
   int unsigned bytes_sent;
   int unsigned idle_cycles;

   websocket_frame_deframer i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_has_data    (rsp_has_data),
      .rsp_msg_opcode  (rsp_msg_opcode),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_message_end (rsp_message_end)
   );

   websocket_frame_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_has_data    (rsp_has_data),
      .rsp_msg_opcode  (rsp_msg_opcode),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_message_end (rsp_message_end),
      .error_count     (error_count),
      .pending_count   (pending_count)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] value);
      int unsigned gap;
      // every fourth stretch of 32 requests goes back to back
      gap = (bytes_sent % 128 >= 96) ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] opcode,
                             input logic masked, input length_form_type form,
                             input logic [63:0] length, input logic [31:0] key,
                             input int unsigned body_bytes);
      logic [6:0] code;
      case (form)
         FORM_16: code = LEN_CODE_16;
         FORM_64: code = LEN_CODE_64;
         default: code = length[6:0];
      endcase
      send_byte({fin, rsv, opcode});
      send_byte({masked, code});
      if (form == FORM_16) begin
         send_byte(length[15:8]);
         send_byte(length[7:0]);
      end else if (form == FORM_64) begin
         for (int i = 7; i >= 0; i--)
            send_byte(length[8 * i +: 8]);
      end
      if (masked)
         for (int i = 3; i >= 0; i--)
            send_byte(key[8 * i +: 8]);
      repeat (body_bytes) send_byte(8'($urandom_range(0, 255)));
   endtask

   // well-formed frame with random flags, opcode and reserved bits; the long length
   // forms are also used with lengths that would fit the short one
   task automatic random_frame();
      length_form_type form;
      int unsigned     pick;
      int unsigned     length;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         form = FORM_SHORT;
         pick = $urandom_range(0, 39);
         if (pick == 0)
            length = 125;
         else if (pick < 5)
            length = $urandom_range(0, 125);
         else
            length = $urandom_range(0, 12);
      end else if (pick < 9) begin
         form   = FORM_16;
         length = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 20);
      end else begin
         form   = FORM_64;
         length = $urandom_range(0, 20);
      end
      send_frame(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), form,
                 64'(length), $urandom, length);
   endtask

   // response side: random stalls, one long hold to fill the block, steady stretches
   initial begin
      int unsigned taken;
      int unsigned wait_cycles;
      taken     = 0;
      rsp_stall = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken == 40)
            wait_cycles = 80;
         else if (taken % 100 >= 70)
            wait_cycles = 0;
         else
            wait_cycles = $urandom_range(0, 3);
         if (wait_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_in_byte = 8'h00;
      bytes_sent  = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty masked fragment: marker comes on the last key byte
      send_frame(1'b0, 3'b000, OP_BINARY, 1'b1, FORM_SHORT, 64'd0, 32'hFFFF_FFFF, 0);
      // empty continuation with reserved bits set, 16-bit length form
      send_frame(1'b0, 3'b111, OP_CONTINUATION, 1'b0, FORM_16, 64'd0, 32'h0, 0);
      // final fragment with a stray opcode that must not replace the message opcode
      send_frame(1'b1, 3'b000, OP_UNDEFINED_F, 1'b0, FORM_64, 64'd1, 32'h0, 1);
      // byte extremes in an unmasked text frame
      send_byte({1'b1, 3'b000, OP_TEXT});
      send_byte(8'd2);
      send_byte(8'h00);
      send_byte(8'hFF);

      while (bytes_sent < TARGET_BYTES) random_frame();

      // length with every bit set: the frame never ends, payload keeps flowing
      send_frame(1'b1, 3'b000, OP_BINARY, 1'b1, FORM_64, 64'hFFFF_FFFF_FFFF_FFFF,
                 $urandom, 24);
      req_valid <= 1'b0;

      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
